// ===== design/lcm_pkg.sv =====
package lcm_pkg;

  // fixed sizes of the command table
  localparam int NUM_WORDS      = 2;
  localparam int MAX_WORD_CHARS = 8;
  localparam int TEXT_W         = 64;
  localparam int LEN_W          = 4;
  localparam int NUM_REGS       = 4;
  localparam int REG_IDX_W      = 2;
  localparam int ADDR_W         = 5;
  localparam int PDATA_W        = 64;

  localparam logic [7:0] CR_BYTE  = 8'h0d;
  localparam logic [7:0] NUL_BYTE = 8'h00;

  // register indexes, byte address is 8 * index
  typedef enum logic [REG_IDX_W-1:0] {
    REG_WORD0_TEXT   = 2'd0,
    REG_WORD0_LENGTH = 2'd1,
    REG_WORD1_TEXT   = 2'd2,
    REG_WORD1_LENGTH = 2'd3
  } reg_idx_t;

  typedef logic [TEXT_W-1:0] word_text_t;
  typedef logic [LEN_W-1:0]  word_len_t;

  // reset contents: "abc" and "bbc", both three characters
  localparam word_text_t WORD0_TEXT_RST = 64'd6513249;
  localparam word_text_t WORD1_TEXT_RST = 64'd6513250;
  localparam word_len_t  WORD0_LEN_RST  = 4'd3;
  localparam word_len_t  WORD1_LEN_RST  = 4'd3;

  // usable length of a word: clamped, and cut at its first nul character
  function automatic word_len_t eff_len(word_text_t text, word_len_t len);
    word_len_t n;
    word_len_t res;
    logic      found;
    n     = (len > word_len_t'(MAX_WORD_CHARS)) ? word_len_t'(MAX_WORD_CHARS) : len;
    res   = n;
    found = 1'b0;
    for (int i = 0; i < MAX_WORD_CHARS; i++) begin
      if (!found && (word_len_t'(i) < n) && (text[8*i +: 8] == NUL_BYTE)) begin
        res   = word_len_t'(i);
        found = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

// ===== design/line_command_matcher_core.sv =====
// a carriage return item shows its result on m_* in the cycle after it is accepted
// throughput: one byte item per cycle while s_tready is high; each stored data or nul byte
// updates the compare flags in a single step; a stalled result blocks new input only
// until m_tready takes it; rst (synchronous, active high) clears the line state and the
// result valid flag and loads the command table with "abc" and "bbc", three characters each
module line_command_matcher_core #(
  parameter int LINE_CAPACITY = 64,
  localparam int POS_W    = $clog2(LINE_CAPACITY + 1),
  localparam int M_DATA_W = ((POS_W + 3 + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  // input stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // rx_byte
  // result stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [M_DATA_W-1:0]        m_tdata,   // matched, word_index, line_length, too_long
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lcm_pkg::ADDR_W-1:0] paddr,
  input  logic [lcm_pkg::PDATA_W-1:0] pwdata,
  output logic [lcm_pkg::PDATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int CMP_W = (POS_W > lcm_pkg::LEN_W) ? POS_W : lcm_pkg::LEN_W;

  // command table
  lcm_pkg::word_text_t word_text [lcm_pkg::NUM_WORDS];
  lcm_pkg::word_len_t  word_len  [lcm_pkg::NUM_WORDS];

  // line state
  logic [POS_W-1:0]               char_position;
  logic [lcm_pkg::NUM_WORDS-1:0]  word_mismatch;
  logic                           string_ended;
  logic                           overflow_seen;

  // result register
  logic                           out_valid;
  logic                           out_matched;
  logic                           out_word_index;
  logic [POS_W-1:0]               out_line_length;
  logic                           out_too_long;

  logic                           in_fire;
  logic                           cfg_write;
  lcm_pkg::reg_idx_t              cfg_idx;
  logic                           is_cr;
  logic                           is_nul;
  logic                           at_capacity;
  logic [CMP_W-1:0]               pos_ext;
  logic [2:0]                     byte_sel;
  lcm_pkg::word_len_t             eff   [lcm_pkg::NUM_WORDS];
  logic [lcm_pkg::NUM_WORDS-1:0]  len_miss;   // word length differs from the line so far, or the line is empty
  logic [lcm_pkg::NUM_WORDS-1:0]  char_miss;  // current byte does not fit the word
  logic [lcm_pkg::NUM_WORDS-1:0]  final_miss;
  logic [lcm_pkg::NUM_WORDS-1:0]  word_mismatch_next;
  logic                           hit;
  logic                           hit_index;

  // a result slot is free when empty or being drained this cycle
  assign s_tready = !out_valid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  assign is_cr       = (s_tdata == lcm_pkg::CR_BYTE);
  assign is_nul      = (s_tdata == lcm_pkg::NUL_BYTE);
  assign at_capacity = (char_position == POS_W'(LINE_CAPACITY));
  assign pos_ext     = CMP_W'(char_position);
  assign byte_sel    = 3'(char_position);

  // per-word compare of the incoming byte
  always_comb begin
    for (int w = 0; w < lcm_pkg::NUM_WORDS; w++) begin
      eff[w]       = lcm_pkg::eff_len(word_text[w], word_len[w]);
      len_miss[w]  = (CMP_W'(eff[w]) != pos_ext) || (char_position == '0);
      char_miss[w] = (pos_ext >= CMP_W'(eff[w])) ||
                     (word_text[w][8*byte_sel +: 8] != s_tdata);
      final_miss[w] = word_mismatch[w] || (!string_ended && len_miss[w]);
    end
  end

  // first surviving word wins
  always_comb begin
    hit       = 1'b0;
    hit_index = 1'b0;
    for (int w = lcm_pkg::NUM_WORDS - 1; w >= 0; w--) begin
      if (!final_miss[w]) begin
        hit       = 1'b1;
        hit_index = 1'(w);
      end
    end
    if (overflow_seen) begin
      hit       = 1'b0;
      hit_index = 1'b0;
    end
  end

  // mismatch update for a data or nul byte
  always_comb begin
    word_mismatch_next = word_mismatch;
    if (!string_ended) begin
      if (is_nul) begin
        word_mismatch_next = word_mismatch | len_miss;
      end else begin
        word_mismatch_next = word_mismatch | char_miss;
      end
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      word_mismatch <= '0;
      string_ended  <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (in_fire) begin
      if (is_cr) begin
        // end of line: start fresh
        char_position <= '0;
        word_mismatch <= '0;
        string_ended  <= 1'b0;
        overflow_seen <= 1'b0;
      end else if (!overflow_seen) begin
        if (at_capacity) begin
          // one byte past the buffer: drop the rest of the line
          overflow_seen <= 1'b1;
        end else begin
          word_mismatch <= word_mismatch_next;
          if (is_nul) begin
            string_ended <= 1'b1;
          end
          char_position <= char_position + POS_W'(1);
        end
      end
    end
  end

  // result register, loaded only on a carriage return
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && is_cr) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_cr) begin
      out_matched     <= hit;
      out_word_index  <= hit_index;
      out_line_length <= char_position;
      out_too_long    <= overflow_seen;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_DATA_W'({out_too_long, out_line_length, out_word_index, out_matched});

  // configuration port, 8 bytes per register
  assign pready    = 1'b1;
  assign cfg_idx   = lcm_pkg::reg_idx_t'(paddr[lcm_pkg::ADDR_W-1:3]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_text[0] <= lcm_pkg::WORD0_TEXT_RST;
      word_len[0]  <= lcm_pkg::WORD0_LEN_RST;
      word_text[1] <= lcm_pkg::WORD1_TEXT_RST;
      word_len[1]  <= lcm_pkg::WORD1_LEN_RST;
    end else if (cfg_write) begin
      case (cfg_idx)
        lcm_pkg::REG_WORD0_TEXT:   word_text[0] <= pwdata;
        lcm_pkg::REG_WORD0_LENGTH: word_len[0]  <= pwdata[lcm_pkg::LEN_W-1:0];
        lcm_pkg::REG_WORD1_TEXT:   word_text[1] <= pwdata;
        lcm_pkg::REG_WORD1_LENGTH: word_len[1]  <= pwdata[lcm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lcm_pkg::REG_WORD0_TEXT:   prdata = word_text[0];
      lcm_pkg::REG_WORD0_LENGTH: prdata = lcm_pkg::PDATA_W'(word_len[0]);
      lcm_pkg::REG_WORD1_TEXT:   prdata = word_text[1];
      lcm_pkg::REG_WORD1_LENGTH: prdata = lcm_pkg::PDATA_W'(word_len[1]);
      default:                   prdata = '0;
    endcase
  end

`ifndef SYNTHESIS
  // an overflowed line never reports a match
  a_no_match_when_long: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_too_long |-> !out_matched)
    else $error("match reported on too-long line");

  // an empty line never reports a match
  a_empty_no_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_line_length == '0) |-> !out_matched)
    else $error("match reported on empty line");

  // a carriage return always produces a result next cycle
  a_cr_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_cr |=> out_valid)
    else $error("carriage return produced no result");

  // overflow only once the buffer is full
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> at_capacity)
    else $error("overflow flag without full buffer");

  // a line that a nul has ended is never empty
  a_ended_nonempty: assert property (@(posedge clk) disable iff (rst)
    string_ended |-> (char_position != '0))
    else $error("string ended on empty line");
`endif

endmodule
